@@ design/csv_field_delimiter_rewriter_macros.svh @@
// ----------------------------------------------------------------------------
// CSV field delimiter rewriter: assertion macros
// Short forms for the concurrent checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef CSV_FIELD_DELIMITER_REWRITER_MACROS_SVH
`define CSV_FIELD_DELIMITER_REWRITER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CFDR_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle implication failed");

// The consequent must hold in the cycle after the antecedent.
`define CFDR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle implication failed");

`endif

@@ design/cfdr_pkg.sv @@
// ----------------------------------------------------------------------------
// CSV field delimiter rewriter package
// Character constants, widths and the pending result descriptor.
// ----------------------------------------------------------------------------
`default_nettype none

package cfdr_pkg;

    localparam int CODE_WIDTH = 21;

    typedef logic [CODE_WIDTH-1:0] code_t;

    localparam code_t CH_QUOTE        = code_t'(34);
    localparam code_t CH_UNDERSCORE   = code_t'(95);
    localparam code_t CH_BAR          = code_t'(124);
    localparam code_t CH_NEWLINE      = code_t'(10);
    localparam code_t RESET_SEPARATOR = code_t'(59);

    // Results still owed for one accepted item: an optional "_|_" and an
    // optional trailing character.
    typedef struct packed {
        logic       has_delim;
        logic       has_tail;
        code_t      tail_char;
        logic       tail_done;
        logic [1:0] step;
    } burst_t;

endpackage

`default_nettype wire

@@ design/csv_field_delimiter_rewriter.sv @@
// ----------------------------------------------------------------------------
// CSV field delimiter rewriter
// Rewrites CSV records one character at a time into "_|_" separated fields.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries one item per transfer: a code
//   point, or a line-end marker when line_end is set. Output channel
//   (out_valid / out_stall) carries one result character per transfer; last
//   marks the final result of an input item and line_done the line
//   terminator. The delimiter register is written through cfg_valid /
//   cfg_ready with field_delimiter as data; cfg_ready is always high.
//   An item is parsed in the cycle it is accepted. Its results pass through
//   the pending register and then the output register. An item has 0 to 4
//   results, which leave the pending register one at a time, so items with
//   at most one result flow at one per cycle while out_stall is low. The
//   next item is accepted in the cycle the previous item's last result moves
//   into the output register. Reset clears the parse state, the line flag,
//   the valid flags of both result stages and loads the delimiter with ';'.
//   While out_stall is high and the output register is full, that register
//   holds, and if an item is pending it stalls and in_stall is high.
// ----------------------------------------------------------------------------
`default_nettype none

`include "csv_field_delimiter_rewriter_macros.svh"

module csv_field_delimiter_rewriter (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [20:0] field_delimiter,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [20:0] code_point,
    input  wire logic        line_end,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [20:0]      out_char,
    output logic             line_done,
    output logic             last
);

    typedef enum logic [2:0] {
        ST_INITIAL   = 3'd0,
        ST_NEW_FIELD = 3'd1,
        ST_QUOTED    = 3'd2,
        ST_REGULAR   = 3'd3,
        ST_END_QUOTE = 3'd4
    } parse_state_t;

    parse_state_t     state_reg, state_next;
    logic             line_out_reg, line_out_next;
    cfdr_pkg::code_t  delim_reg;
    logic             pend_valid_reg, pend_valid_next;
    cfdr_pkg::burst_t pend_reg, pend_next;
    logic             out_valid_reg, out_valid_next;
    cfdr_pkg::code_t  out_char_reg, out_char_next;
    logic             line_done_reg, line_done_next;
    logic             last_reg, last_next;

    cfdr_pkg::code_t  ch;
    cfdr_pkg::burst_t burst;
    logic             in_take;
    logic             out_free;
    logic             pend_fire;
    logic [2:0]       pend_cnt;
    logic             pend_is_last;
    logic             in_delim_part;

    assign ch        = cfdr_pkg::code_t'(code_point);
    assign cfg_ready = 1'b1;

    // Parse the incoming item into the results it owes and the next state.
    always_comb
    begin
        burst           = '0;
        burst.tail_char = ch;
        state_next      = state_reg;
        if (line_end)
        begin
            burst.has_delim = (state_reg == ST_NEW_FIELD);
            burst.has_tail  = line_out_reg || (state_reg == ST_NEW_FIELD);
            burst.tail_char = cfdr_pkg::CH_NEWLINE;
            burst.tail_done = 1'b1;
            state_next      = ST_INITIAL;
        end
        else
        begin
            unique case (state_reg)
                ST_NEW_FIELD:
                begin
                    burst.has_delim = 1'b1;
                    if (ch == cfdr_pkg::CH_QUOTE)
                    begin
                        state_next = ST_QUOTED;
                    end
                    else if (ch != delim_reg)
                    begin
                        burst.has_tail = 1'b1;
                        state_next     = ST_REGULAR;
                    end
                end
                ST_QUOTED:
                begin
                    if (ch == cfdr_pkg::CH_QUOTE)
                    begin
                        state_next = ST_END_QUOTE;
                    end
                    else
                    begin
                        burst.has_tail = 1'b1;
                    end
                end
                ST_REGULAR, ST_END_QUOTE:
                begin
                    if (ch == delim_reg)
                    begin
                        state_next = ST_NEW_FIELD;
                    end
                    else
                    begin
                        burst.has_tail = 1'b1;
                    end
                end
                default:
                begin
                    if (ch == delim_reg)
                    begin
                        state_next = ST_NEW_FIELD;
                    end
                    else
                    begin
                        burst.has_tail = 1'b1;
                        state_next     = ST_REGULAR;
                    end
                end
            endcase
        end
        line_out_next = line_end ? 1'b0
                                 : (line_out_reg || burst.has_delim || burst.has_tail);
    end

    assign pend_cnt      = (pend_reg.has_delim ? 3'd3 : 3'd0) + {2'b00, pend_reg.has_tail};
    assign pend_is_last  = ({1'b0, pend_reg.step} == (pend_cnt - 3'd1));
    assign out_free      = !out_valid_reg || !out_stall;
    assign pend_fire     = pend_valid_reg && out_free;
    assign in_stall      = pend_valid_reg && !(pend_fire && pend_is_last);
    assign in_take       = in_valid && !in_stall;
    assign in_delim_part = pend_reg.has_delim && (pend_reg.step != 2'd3);

    always_comb
    begin
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        if (in_take && (burst.has_delim || burst.has_tail))
        begin
            pend_valid_next = 1'b1;
            pend_next       = burst;
        end
        else if (pend_fire)
        begin
            if (pend_is_last)
            begin
                pend_valid_next = 1'b0;
            end
            else
            begin
                pend_next.step = pend_reg.step + 2'd1;
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_char_next  = out_char_reg;
        line_done_next = line_done_reg;
        last_next      = last_reg;
        if (pend_fire)
        begin
            out_valid_next = 1'b1;
            last_next      = pend_is_last;
            if (in_delim_part)
            begin
                out_char_next  = (pend_reg.step == 2'd1) ? cfdr_pkg::CH_BAR
                                                         : cfdr_pkg::CH_UNDERSCORE;
                line_done_next = 1'b0;
            end
            else
            begin
                out_char_next  = pend_reg.tail_char;
                line_done_next = pend_reg.tail_done;
            end
        end
        else if (out_free)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_INITIAL;
            line_out_reg   <= 1'b0;
            delim_reg      <= cfdr_pkg::RESET_SEPARATOR;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (in_take)
            begin
                state_reg    <= state_next;
                line_out_reg <= line_out_next;
            end
            if (cfg_valid && cfg_ready)
            begin
                delim_reg <= cfdr_pkg::code_t'(field_delimiter);
            end
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_reg      <= pend_next;
        out_char_reg  <= out_char_next;
        line_done_reg <= line_done_next;
        last_reg      <= last_next;
    end

    assign out_valid = out_valid_reg;
    assign out_char  = 21'(out_char_reg);
    assign line_done = line_done_reg;
    assign last      = last_reg;

    `CFDR_ASSERT_NEXT(a_line_end_resets, clk, rst_n, in_take && line_end,
        (state_reg == ST_INITIAL) && !line_out_reg)
    `CFDR_ASSERT_NEXT(a_burst_loaded, clk, rst_n,
        in_take && (burst.has_delim || burst.has_tail), pend_valid_reg)
    `CFDR_ASSERT_IMPLY(a_step_in_range, clk, rst_n, pend_valid_reg,
        ({1'b0, pend_reg.step} < pend_cnt))
    `CFDR_ASSERT_IMPLY(a_terminator_is_last, clk, rst_n, out_valid_reg && line_done_reg,
        last_reg && (out_char_reg == cfdr_pkg::CH_NEWLINE))

endmodule

`default_nettype wire

@@ dv/csv_field_delimiter_rewriter_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CSV field delimiter rewriter: result checker
// Watches the delimiter register port and both item channels, keeps its own
// copy of the parse state and the delimiter, works out the characters each
// accepted item must produce and compares every accepted result with them.
// ----------------------------------------------------------------------------

module csv_field_delimiter_rewriter_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [20:0] field_delimiter,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [20:0] code_point,
    input  logic        line_end,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [20:0] out_char,
    input  logic        line_done,
    input  logic        last,
    output int          mismatch_count,
    output int          results_owed
);

    localparam int MAX_REPORTS = 60;

    typedef enum logic [2:0] {
        PS_INITIAL   = 3'd0,
        PS_NEW_FIELD = 3'd1,
        PS_QUOTED    = 3'd2,
        PS_REGULAR   = 3'd3,
        PS_END_QUOTE = 3'd4
    } parse_t;

    typedef struct packed {
        cfdr_pkg::code_t ch;
        logic            done;
        logic            tail;
    } out_char_t;

    out_char_t       owed_q[$];
    out_char_t       burst_q[$];
    parse_t          parse_state;
    logic            line_busy;
    cfdr_pkg::code_t delim;

    initial mismatch_count = 0;
    assign results_owed = owed_q.size();

    function automatic void emit(cfdr_pkg::code_t ch, logic done);
        out_char_t r;
        r.ch   = ch;
        r.done = done;
        r.tail = 1'b0;
        burst_q.push_back(r);
        line_busy = 1'b1;
    endfunction

    function automatic void emit_separator();
        emit(cfdr_pkg::CH_UNDERSCORE, 1'b0);
        emit(cfdr_pkg::CH_BAR, 1'b0);
        emit(cfdr_pkg::CH_UNDERSCORE, 1'b0);
    endfunction

    // Works out the characters one accepted item produces and queues them.
    function automatic void rewrite_item(cfdr_pkg::code_t cp, logic eol);
        burst_q.delete();
        if (eol)
        begin
            if (parse_state == PS_NEW_FIELD)
                emit_separator();
            if (line_busy)
                emit(cfdr_pkg::CH_NEWLINE, 1'b1);
            parse_state = PS_INITIAL;
            line_busy   = 1'b0;
        end
        else
        begin
            case (parse_state)
                PS_NEW_FIELD:
                begin
                    // The quote test wins over the delimiter test here.
                    emit_separator();
                    if (cp == cfdr_pkg::CH_QUOTE)
                        parse_state = PS_QUOTED;
                    else if (cp != delim)
                    begin
                        emit(cp, 1'b0);
                        parse_state = PS_REGULAR;
                    end
                end
                PS_QUOTED:
                begin
                    if (cp == cfdr_pkg::CH_QUOTE)
                        parse_state = PS_END_QUOTE;
                    else
                        emit(cp, 1'b0);
                end
                PS_REGULAR, PS_END_QUOTE:
                begin
                    if (cp == delim)
                        parse_state = PS_NEW_FIELD;
                    else
                        emit(cp, 1'b0);
                end
                default:
                begin
                    if (cp == delim)
                        parse_state = PS_NEW_FIELD;
                    else
                    begin
                        emit(cp, 1'b0);
                        parse_state = PS_REGULAR;
                    end
                end
            endcase
        end
        if (burst_q.size() > 0)
            burst_q[burst_q.size() - 1].tail = 1'b1;
        foreach (burst_q[i])
            owed_q.push_back(burst_q[i]);
    endfunction

    function automatic void report(string what, int exp_val, int act_val);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, exp_val,
                     act_val);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        out_char_t want;
        if (!rst_n)
        begin
            delim       = cfdr_pkg::RESET_SEPARATOR;
            parse_state = PS_INITIAL;
            line_busy   = 1'b0;
            owed_q.delete();
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (owed_q.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("%0t: unexpected result, expected none, actual %0h",
                                 $time, out_char);
                end
                else
                begin
                    want = owed_q.pop_front();
                    if (out_char !== want.ch)
                        report("out_char", want.ch, out_char);
                    if (line_done !== want.done)
                        report("line_done", want.done, line_done);
                    if (last !== want.tail)
                        report("last", want.tail, last);
                end
            end
            // An item accepted at the same edge as a register write still
            // sees the old delimiter.
            if (in_valid && !in_stall)
                rewrite_item(code_point, line_end);
            if (cfg_valid && cfg_ready)
                delim = field_delimiter;
        end
    end

endmodule

@@ dv/tb_csv_field_delimiter_rewriter.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CSV field delimiter rewriter testbench
// Drives directed records covering every parse state, then random CSV lines
// and noise under several delimiter settings, with random input gaps and
// output stalls. The checker beside the block does all result checking.
// ----------------------------------------------------------------------------

module tb_csv_field_delimiter_rewriter;

    localparam int              RANDOM_ITEMS = 370;
    localparam int              PHASE_ITEMS  = 60;
    localparam int              DRAIN_CYCLES = 6;
    localparam int              CYCLE_LIMIT  = 200000;
    localparam cfdr_pkg::code_t CH_COMMA     = cfdr_pkg::code_t'(44);
    localparam cfdr_pkg::code_t CH_TAB       = cfdr_pkg::code_t'(9);
    localparam cfdr_pkg::code_t CODE_MAX     = cfdr_pkg::code_t'(21'h1FFFFF);

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [20:0] field_delimiter = cfdr_pkg::RESET_SEPARATOR;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [20:0] code_point = '0;
    logic        line_end = 1'b0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [20:0] out_char;
    logic        line_done;
    logic        last;

    int              mismatch_count;
    int              results_owed;
    int              items_sent = 0;
    int              cycle_count = 0;
    bit              idle_on = 1'b1;
    cfdr_pkg::code_t cur_delim = cfdr_pkg::RESET_SEPARATOR;

    csv_field_delimiter_rewriter dut (.*);

    csv_field_delimiter_rewriter_checker checker_i (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .field_delimiter(field_delimiter),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .code_point     (code_point),
        .line_end       (line_end),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .out_char       (out_char),
        .line_done      (line_done),
        .last           (last),
        .mismatch_count (mismatch_count),
        .results_owed   (results_owed)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    always @(negedge clk)
        out_stall <= idle_on && ($urandom_range(99) < 17);

    // Called at a falling edge; returns at the falling edge after acceptance
    // with in_valid still high.
    task automatic push_item(input cfdr_pkg::code_t cp, input logic eol);
        while (idle_on && $urandom_range(99) < 17)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid   <= 1'b1;
        code_point <= cp;
        line_end   <= eol;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        @(negedge clk);
        items_sent++;
    endtask

    task automatic end_line();
        push_item(cfdr_pkg::code_t'($urandom), 1'b1);
    endtask

    // Holds the sender until every owed result is out and the block is quiet.
    task automatic drain();
        in_valid <= 1'b0;
        while (results_owed != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_delimiter(input cfdr_pkg::code_t value);
        cfg_valid       <= 1'b1;
        field_delimiter <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
        cur_delim = value;
    endtask

    function automatic cfdr_pkg::code_t content_char(input cfdr_pkg::code_t sep);
        case ($urandom_range(15))
            0:       return cfdr_pkg::code_t'($urandom);
            1:       return sep;
            2:       return cfdr_pkg::CH_QUOTE;
            3:       return ($urandom_range(1) == 0) ? cfdr_pkg::CH_NEWLINE
                                                     : cfdr_pkg::code_t'(0);
            default: return cfdr_pkg::code_t'($urandom_range(32, 126));
        endcase
    endfunction

    // One line of plain or quoted fields split by the delimiter; random content may hold it or a quote.
    task automatic send_record(input cfdr_pkg::code_t sep);
        int n_fields;
        int n_chars;
        n_fields = $urandom_range(1, 5);
        for (int f = 0; f < n_fields; f++)
        begin
            if (f > 0)
                push_item(sep, 1'b0);
            n_chars = $urandom_range(0, 6);
            if ($urandom_range(2) == 0)
            begin
                push_item(cfdr_pkg::CH_QUOTE, 1'b0);
                repeat (n_chars) push_item(content_char(sep), 1'b0);
                push_item(cfdr_pkg::CH_QUOTE, 1'b0);
            end
            else
            begin
                repeat (n_chars) push_item(content_char(sep), 1'b0);
            end
        end
        if ($urandom_range(5) == 0)
            push_item(sep, 1'b0);
        end_line();
    endtask

    task automatic send_noise();
        repeat ($urandom_range(1, 12))
            push_item(cfdr_pkg::code_t'($urandom), $urandom_range(4) == 0);
    endtask

    initial
    begin
        cfdr_pkg::code_t phase_delims[7];
        int              phase;
        int              phase_end;

        phase_delims = '{CH_COMMA, cfdr_pkg::code_t'(0), CODE_MAX, cfdr_pkg::CH_QUOTE,
                         CH_TAB, cfdr_pkg::CH_NEWLINE, cfdr_pkg::RESET_SEPARATOR};
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed part with the reset delimiter.
        end_line();
        push_item(cfdr_pkg::code_t'("a"), 1'b0);
        push_item(cfdr_pkg::RESET_SEPARATOR, 1'b0);
        push_item(cfdr_pkg::CH_QUOTE, 1'b0);
        push_item(cfdr_pkg::RESET_SEPARATOR, 1'b0);
        push_item(cfdr_pkg::code_t'(0), 1'b0);
        push_item(cfdr_pkg::CH_QUOTE, 1'b0);
        push_item(cfdr_pkg::code_t'("x"), 1'b0);
        push_item(cfdr_pkg::RESET_SEPARATOR, 1'b0);
        push_item(cfdr_pkg::RESET_SEPARATOR, 1'b0);
        push_item(cfdr_pkg::code_t'("z"), 1'b0);
        push_item(cfdr_pkg::RESET_SEPARATOR, 1'b0);
        end_line();
        push_item(cfdr_pkg::CH_QUOTE, 1'b0);
        push_item(cfdr_pkg::CH_NEWLINE, 1'b0);
        push_item(CODE_MAX, 1'b0);
        end_line();
        push_item(cfdr_pkg::RESET_SEPARATOR, 1'b0);
        end_line();
        push_item(cfdr_pkg::RESET_SEPARATOR, 1'b0);
        push_item(cfdr_pkg::CH_QUOTE, 1'b0);
        push_item(cfdr_pkg::code_t'("q"), 1'b0);
        end_line();

        // Delimiter equal to the quote character.
        drain();
        write_delimiter(cfdr_pkg::CH_QUOTE);
        push_item(cfdr_pkg::code_t'("a"), 1'b0);
        push_item(cfdr_pkg::CH_QUOTE, 1'b0);
        push_item(cfdr_pkg::CH_QUOTE, 1'b0);
        push_item(cfdr_pkg::code_t'("b"), 1'b0);
        push_item(cfdr_pkg::CH_QUOTE, 1'b0);
        push_item(cfdr_pkg::CH_QUOTE, 1'b0);
        end_line();

        // Random part: one delimiter setting per phase, drained in between.
        phase = 0;
        phase_end = items_sent + RANDOM_ITEMS;
        while (items_sent < phase_end)
        begin
            drain();
            if (phase < 7)
                write_delimiter(phase_delims[phase]);
            else
                write_delimiter(($urandom_range(1) == 0)
                                ? cfdr_pkg::code_t'($urandom)
                                : cfdr_pkg::code_t'($urandom_range(32, 126)));
            // One phase runs with no gaps and no stalls at all.
            idle_on = (phase != 2);
            for (int n = items_sent + PHASE_ITEMS; items_sent < n && items_sent < phase_end;)
            begin
                if ($urandom_range(7) == 0)
                    send_noise();
                else
                    send_record(cur_delim);
            end
            idle_on = 1'b1;
            phase++;
        end

        in_valid <= 1'b0;
        while (results_owed != 0)
            @(negedge clk);
        repeat (20) @(negedge clk);
        if (mismatch_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
